>>> rtl/core/irlm_pkg.sv
// shared types, constants and the linearization table of the ir range filter
package irlm_pkg;

   // fixed field widths
   localparam int ADC_W      = 10;
   localparam int LIN_IN_W   = 8;
   localparam int DIST_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // default sizes of the stores
   localparam int HISTORY_DEPTH_DEF = 128;
   localparam int WINDOW_SIZE_DEF   = 7;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] DROP_LAG_RST   = 7'd10;
   localparam logic [CSR_DATA_W-1:0] DROP_DELTA_RST = 7'd10;

   // distance clamp limits in centimetres
   localparam int DIST_MIN = 10;
   localparam int DIST_MAX = 75;

   typedef logic [DIST_W-1:0] dist_type;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DROP_LAG   = 1'b0,
      CSR_DROP_DELTA = 1'b1
   } csr_index_type;

   // drop detector settings handed to the back end
   typedef struct packed {
      logic [CSR_DATA_W-1:0] drop_lag;
      logic [CSR_DATA_W-1:0] drop_delta;
   } drop_cfg_type;

   typedef logic [(1<<LIN_IN_W)-1:0][DIST_W-1:0] lin_table_type;

   // one table entry: five sloped segments between two flat ends, truncated, then clamped
   function automatic dist_type lin_entry(int b);
      int d;
      if (b > 132)
         d = 10;
      else if (b > 91)
         d = (2610 - 12 * b) / 100;
      else if (b > 70)
         d = (3667 - 24 * b) / 100;
      else if (b > 49)
         d = (5333 - 48 * b) / 100;
      else if (b > 37)
         d = (7083 - 83 * b) / 100;
      else if (b > 22)
         d = 114 - 2 * b;
      else
         d = 75;
      if (d < DIST_MIN)
         d = DIST_MIN;
      if (d > DIST_MAX)
         d = DIST_MAX;
      return dist_type'(d);
   endfunction

   // whole table, built at elaboration
   function automatic lin_table_type build_lin_table();
      lin_table_type t;
      for (int i = 0; i < (1 << LIN_IN_W); i++) begin
         t[i] = lin_entry(i);
      end
      return t;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();

endpackage

>>> rtl/core/irlm_ram.sv
// generic single write port ram with registered read
module irlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/irlm_front.sv
// front end: takes converter samples and maps them to centimetres
module irlm_front (
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [irlm_pkg::ADC_W-1:0]   req_adc_sample,
   input  logic                         q_full,
   input  logic                         clr_busy,
   output logic                         push_valid,
   output irlm_pkg::dist_type           push_data
);

   logic [irlm_pkg::LIN_IN_W-1:0] lin_idx;

   // take a request whenever the queue has room and the ring is not being cleared
   assign req_ready  = !q_full && !clr_busy;
   assign push_valid = req_valid && req_ready;

   // drop the two low bits, look up the distance
   assign lin_idx   = req_adc_sample[irlm_pkg::ADC_W-1 -: irlm_pkg::LIN_IN_W];
   assign push_data = irlm_pkg::LIN_TABLE[lin_idx];

endmodule

>>> rtl/core/irlm_queue.sv
// two-entry queue of raw distances between front and back end
module irlm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  irlm_pkg::dist_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output irlm_pkg::dist_type  head
);

   irlm_pkg::dist_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push_valid ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop)
         count_in = count_ff + 2'd1;
      else if (!push_valid && pop)
         count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/irlm_back.sv
// back end: sliding window median, history ring and drop detector
module irlm_back #(
   parameter int HISTORY_DEPTH = irlm_pkg::HISTORY_DEPTH_DEF,
   parameter int WINDOW_SIZE   = irlm_pkg::WINDOW_SIZE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  irlm_pkg::drop_cfg_type      cfg,
   input  logic                        q_empty,
   input  irlm_pkg::dist_type          q_head,
   output logic                        q_pop,
   output logic                        clr_busy,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [irlm_pkg::DIST_W-1:0] rsp_raw_distance,
   output logic [irlm_pkg::DIST_W-1:0] rsp_median_distance,
   output logic                        rsp_drop_seen
);

   localparam int HA  = $clog2(HISTORY_DEPTH);
   localparam int HA1 = HA + 1;
   localparam int WS  = $clog2(WINDOW_SIZE);
   localparam int RW  = $clog2(WINDOW_SIZE);
   localparam int MID = WINDOW_SIZE / 2;
   localparam int LW  = irlm_pkg::CSR_DATA_W;

   // window and ring pointers
   irlm_pkg::dist_type win_ff [WINDOW_SIZE];
   irlm_pkg::dist_type win_new [WINDOW_SIZE];
   logic [WS-1:0]      win_slot_ff, win_slot_in;
   logic [HA-1:0]      hist_slot_ff, hist_slot_in;

   // ring clearing pass
   logic               clr_busy_ff, clr_busy_in;
   logic [HA-1:0]      clr_idx_ff, clr_idx_in;

   // median stage results
   logic [RW-1:0]      rank_c [WINDOW_SIZE];
   irlm_pkg::dist_type med_c;

   // ring read address
   logic [LW-1:0]      lag_m;
   logic [HA1-1:0]     past_sum;
   logic [HA-1:0]      past_idx;
   logic               bypass_c;

   // compare stage
   logic               b_valid_ff, b_valid_in;
   irlm_pkg::dist_type b_raw_ff;
   irlm_pkg::dist_type b_med_ff;
   logic               b_bypass_ff;
   irlm_pkg::dist_type rd_data;
   irlm_pkg::dist_type lagged;
   logic               drop_c;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   irlm_pkg::dist_type rsp_raw_ff;
   irlm_pkg::dist_type rsp_med_ff;
   logic               rsp_drop_ff;

   // pipeline control
   logic               out_free;
   logic               b_adv;
   logic               a_fire;

   logic               ram_wr_en;
   logic [HA-1:0]      ram_wr_addr;
   irlm_pkg::dist_type ram_wr_data;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_adv    = b_valid_ff && out_free;
   assign a_fire   = !q_empty && !clr_busy_ff && (!b_valid_ff || b_adv);
   assign q_pop    = a_fire;
   assign clr_busy = clr_busy_ff;

   // window with the new distance in place
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         win_new[i] = (win_slot_ff == WS'(i)) ? q_head : win_ff[i];
      end
   end

   // rank of each entry, ties broken by position
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         rank_c[i] = '0;
         for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (j != i) begin
               if ((win_new[j] < win_new[i]) || ((win_new[j] == win_new[i]) && (j < i)))
                  rank_c[i] = rank_c[i] + RW'(1);
            end
         end
      end
   end

   // entry of middle rank is the median
   always_comb begin
      med_c = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if (rank_c[i] == RW'(MID))
            med_c = win_new[i];
      end
   end

   // lag folded into the ring depth, at most eight subtract steps
   always_comb begin
      lag_m = cfg.drop_lag;
      for (int k = 0; k < 8; k++) begin
         if (int'(lag_m) >= HISTORY_DEPTH)
            lag_m = lag_m - LW'(HISTORY_DEPTH);
      end
   end

   // lagged ring index, current slot when the lag folds to zero
   always_comb begin
      past_sum = {1'b0, hist_slot_ff} + HA1'(HISTORY_DEPTH) - HA1'(lag_m);
      if (int'(past_sum) >= HISTORY_DEPTH)
         past_sum = past_sum - HA1'(HISTORY_DEPTH);
      past_idx = past_sum[HA-1:0];
      bypass_c = (lag_m == '0);
   end

   // ring write: zeros while clearing, else the new median
   assign ram_wr_en   = clr_busy_ff || a_fire;
   assign ram_wr_addr = clr_busy_ff ? clr_idx_ff : hist_slot_ff;
   assign ram_wr_data = clr_busy_ff ? '0 : med_c;

   irlm_ram #(
      .WIDTH (irlm_pkg::DIST_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (a_fire),
      .rd_addr (past_idx),
      .rd_data (rd_data)
   );

   // pointer and clear pass next state
   always_comb begin
      win_slot_in  = win_slot_ff;
      hist_slot_in = hist_slot_ff;
      if (a_fire) begin
         win_slot_in  = (win_slot_ff == WS'(WINDOW_SIZE - 1)) ? '0 : win_slot_ff + WS'(1);
         hist_slot_in = (hist_slot_ff == HA'(HISTORY_DEPTH - 1)) ? '0 : hist_slot_ff + HA'(1);
      end
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + HA'(1);
         if (clr_idx_ff == HA'(HISTORY_DEPTH - 1))
            clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            win_ff[i] <= '0;
         end
         win_slot_ff  <= '0;
         hist_slot_ff <= '0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         if (a_fire) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
               win_ff[i] <= win_new[i];
            end
         end
         win_slot_ff  <= win_slot_in;
         hist_slot_ff <= hist_slot_in;
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
      end
   end

   // compare stage registers
   always_comb begin
      b_valid_in = b_valid_ff;
      if (a_fire)
         b_valid_in = 1'b1;
      else if (b_adv)
         b_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         b_valid_ff <= 1'b0;
      else
         b_valid_ff <= b_valid_in;
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         b_raw_ff    <= q_head;
         b_med_ff    <= med_c;
         b_bypass_ff <= bypass_c;
      end
   end

   // drop test against the lagged median
   always_comb begin
      lagged = b_bypass_ff ? b_med_ff : rd_data;
      drop_c = (lagged >= b_med_ff) && ((lagged - b_med_ff) >= cfg.drop_delta);
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_adv)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         rsp_raw_ff  <= b_raw_ff;
         rsp_med_ff  <= b_med_ff;
         rsp_drop_ff <= drop_c;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_raw_distance    = rsp_raw_ff;
   assign rsp_median_distance = rsp_med_ff;
   assign rsp_drop_seen       = rsp_drop_ff;

   // no window update while the ring is still being cleared
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      a_fire |-> !clr_busy_ff)
      else $error("queue popped during ring clear");

   // a popped item always reaches the compare stage
   a_pop_fills_b: assert property (@(posedge clock) disable iff (reset)
      a_fire |=> b_valid_ff)
      else $error("popped item lost before compare stage");

   // a waiting response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !b_adv)
      else $error("stalled response overwritten");

   // compare stage result lands in the output register
   a_b_to_out: assert property (@(posedge clock) disable iff (reset)
      b_adv |=> rsp_valid_ff)
      else $error("compare stage result dropped");

   // ring pointer stays inside the ring
   a_hist_slot_range: assert property (@(posedge clock) disable iff (reset)
      int'(hist_slot_ff) < HISTORY_DEPTH)
      else $error("history slot out of range");

endmodule

>>> rtl/core/ir_range_linearize_median_top.sv
// top level of the infrared range linearizer with median filter and drop flag
//
//  port group | direction | contents
//  req_       | in        | adc_sample, valid/ready request channel
//  rsp_       | out       | raw_distance, median_distance, drop_seen, valid/ready
//  csr_       | in        | write_en, index, wdata (drop_lag, drop_delta)
//
// one request per cycle sustained while rsp_ready is high; a request goes through the
// queue, the median and ring read, and the compare into the output register.
// after reset the history ring is zeroed one entry per cycle, with req_ready low;
// register writes are taken throughout.
// a stalled response holds in the output register while the compare stage and the
// two-entry queue keep taking requests until they fill.
module ir_range_linearize_median_top #(
   parameter int HISTORY_DEPTH = irlm_pkg::HISTORY_DEPTH_DEF,
   parameter int WINDOW_SIZE   = irlm_pkg::WINDOW_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [irlm_pkg::ADC_W-1:0]      req_adc_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [irlm_pkg::DIST_W-1:0]     rsp_raw_distance,
   output logic [irlm_pkg::DIST_W-1:0]     rsp_median_distance,
   output logic                            rsp_drop_seen,
   input  logic                            csr_write_en,
   input  logic [irlm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irlm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   irlm_pkg::drop_cfg_type cfg_ff, cfg_in;
   irlm_pkg::dist_type     push_data;
   irlm_pkg::dist_type     q_head;
   logic                   push_valid;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;
   logic                   clr_busy;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (irlm_pkg::csr_index_type'(csr_index))
            irlm_pkg::CSR_DROP_LAG:   cfg_in.drop_lag   = csr_wdata;
            irlm_pkg::CSR_DROP_DELTA: cfg_in.drop_delta = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drop_lag   <= irlm_pkg::DROP_LAG_RST;
         cfg_ff.drop_delta <= irlm_pkg::DROP_DELTA_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request intake and linearization
   irlm_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_sample (req_adc_sample),
      .q_full         (q_full),
      .clr_busy       (clr_busy),
      .push_valid     (push_valid),
      .push_data      (push_data)
   );

   // decoupling queue
   irlm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   // filtering and drop detection
   irlm_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .WINDOW_SIZE   (WINDOW_SIZE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_empty             (q_empty),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .clr_busy            (clr_busy),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_raw_distance    (rsp_raw_distance),
      .rsp_median_distance (rsp_median_distance),
      .rsp_drop_seen       (rsp_drop_seen)
   );

endmodule
